// ===== src/ufpc8_pkg.sv =====
// Package for the frame deframer: frame limits, CRC-8 constants and the
// bytewise CRC-8 update (polynomial 0x07, MSB first). No dependencies.
package ufpc8_pkg;

    localparam int unsigned MAX_PAYLOAD = 32;
    localparam int unsigned ADDR_W      = $clog2(MAX_PAYLOAD);

    localparam logic [7:0] CRC_POLY   = 8'h07;
    localparam logic [7:0] CRC_INIT   = 8'h00;
    localparam logic [7:0] CRC_MSB    = 8'h80;
    localparam logic [7:0] HDR_RESET  = 8'hAA;

    localparam logic [7:0] LEN_LIMIT  = 8'(MAX_PAYLOAD);

    localparam logic STATUS_GOOD = 1'b0;
    localparam logic STATUS_BAD  = 1'b1;

    typedef logic [7:0] t_byte;

    function automatic t_byte crc8_feed(input t_byte crc, input t_byte b);
        t_byte c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_MSB) != 8'h00) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== src/uart_frame_parser_crc8_unit.sv =====
// Frame deframer with CRC-8 check; depends on ufpc8_pkg.
// A received byte is taken while o_rx_ready is high. After its CRC byte, a frame with a CRC
// error or empty payload has its result the next cycle; others pass PH_RD and PH_EMIT first.
// Throughput: one received byte per cycle while parsing; the CRC byte waits on a free output.
// Payload memory drains by a read, then an emit, per byte; no byte is taken during the drain.
// Reset clears phase, held fields, CRC and result valid; the header register goes to 0xAA.
module uart_frame_parser_crc8_unit
    import ufpc8_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [7:0]          i_cfg_data,
    input  logic                i_rx_valid,
    output logic                o_rx_ready,
    input  logic [7:0]          i_rx_byte,
    output logic                o_res_valid,
    input  logic                i_res_ready,
    output logic [7:0]          o_frame_command,
    output logic [7:0]          o_frame_sequence,
    output logic [5:0]          o_payload_length,
    output logic [4:0]          o_byte_index,
    output logic [7:0]          o_data_byte,
    output logic                o_status,
    output logic                o_last
);

    localparam logic [2:0] PH_HUNT = 3'd0;
    localparam logic [2:0] PH_CMD  = 3'd1;
    localparam logic [2:0] PH_LEN  = 3'd2;
    localparam logic [2:0] PH_SEQ  = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;
    localparam logic [2:0] PH_CRC  = 3'd5;
    localparam logic [2:0] PH_RD   = 3'd6;
    localparam logic [2:0] PH_EMIT = 3'd7;

    logic [2:0]        r_phase,  n_phase;
    logic [7:0]        r_hdr;
    logic [7:0]        r_cmd,    n_cmd;
    logic [5:0]        r_len,    n_len;
    logic [7:0]        r_seq,    n_seq;
    logic [5:0]        r_fill,   n_fill;
    logic [7:0]        r_crc,    n_crc;
    logic [ADDR_W-1:0] r_rd_idx, n_rd_idx;
    logic [7:0]        r_rd_data;

    logic              r_out_valid, n_out_valid;
    logic [4:0]        r_out_idx,   n_out_idx;
    logic [7:0]        r_out_data,  n_out_data;
    logic              r_out_status, n_out_status;
    logic              r_out_last,  n_out_last;
    logic [7:0]        r_out_cmd,   n_out_cmd;
    logic [7:0]        r_out_seq,   n_out_seq;
    logic [5:0]        r_out_len,   n_out_len;

    logic [7:0]        r_mem [MAX_PAYLOAD];
    logic              mem_we;

    logic              rx_fire;
    logic              out_free;
    logic [7:0]        crc_upd;
    logic [5:0]        fill_inc;
    logic              drain_last;

    assign o_rx_ready = (r_phase <= PH_DATA) || ((r_phase == PH_CRC) && !r_out_valid);
    assign rx_fire    = i_rx_valid && o_rx_ready;
    assign out_free   = !r_out_valid || i_res_ready;
    assign crc_upd    = crc8_feed((r_phase == PH_CMD) ? CRC_INIT : r_crc, i_rx_byte);
    assign fill_inc   = r_fill + 6'd1;
    assign drain_last = ({1'b0, r_rd_idx} + 6'd1) == r_len;

    always_comb begin
        n_phase      = r_phase;
        n_cmd        = r_cmd;
        n_len        = r_len;
        n_seq        = r_seq;
        n_fill       = r_fill;
        n_crc        = r_crc;
        n_rd_idx     = r_rd_idx;
        n_out_valid  = r_out_valid && !i_res_ready;
        n_out_idx    = r_out_idx;
        n_out_data   = r_out_data;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        n_out_cmd    = r_out_cmd;
        n_out_seq    = r_out_seq;
        n_out_len    = r_out_len;
        mem_we       = 1'b0;
        unique case (r_phase)
            PH_HUNT: begin
                if (rx_fire && (i_rx_byte == r_hdr)) begin
                    n_phase = PH_CMD;
                end
            end
            PH_CMD: begin
                if (rx_fire) begin
                    n_cmd   = i_rx_byte;
                    n_crc   = crc_upd;
                    n_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                if (rx_fire) begin
                    if (i_rx_byte <= LEN_LIMIT) begin
                        n_len   = i_rx_byte[5:0];
                        n_crc   = crc_upd;
                        n_phase = PH_SEQ;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
            end
            PH_SEQ: begin
                if (rx_fire) begin
                    n_seq   = i_rx_byte;
                    n_crc   = crc_upd;
                    n_fill  = 6'd0;
                    n_phase = (r_len == 6'd0) ? PH_CRC : PH_DATA;
                end
            end
            PH_DATA: begin
                if (rx_fire) begin
                    mem_we = 1'b1;
                    n_fill = fill_inc;
                    n_crc  = crc_upd;
                    if (fill_inc >= r_len) begin
                        n_phase = PH_CRC;
                    end
                end
            end
            PH_CRC: begin
                if (rx_fire) begin
                    n_out_cmd = r_cmd;
                    n_out_seq = r_seq;
                    n_out_len = r_len;
                    n_out_idx = 5'd0;
                    n_out_data = 8'h00;
                    n_out_last = 1'b1;
                    n_rd_idx  = '0;
                    if (i_rx_byte != r_crc) begin
                        n_out_valid  = 1'b1;
                        n_out_status = STATUS_BAD;
                        n_phase      = PH_HUNT;
                    end else if (r_len == 6'd0) begin
                        n_out_valid  = 1'b1;
                        n_out_status = STATUS_GOOD;
                        n_phase      = PH_HUNT;
                    end else begin
                        n_phase = PH_RD;
                    end
                end
            end
            PH_RD: begin
                n_phase = PH_EMIT;
            end
            PH_EMIT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_idx    = 5'(r_rd_idx);
                    n_out_data   = r_rd_data;
                    n_out_status = STATUS_GOOD;
                    n_out_last   = drain_last;
                    if (drain_last) begin
                        n_phase = PH_HUNT;
                    end else begin
                        n_rd_idx = r_rd_idx + 1'b1;
                        n_phase  = PH_RD;
                    end
                end
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_fill[ADDR_W-1:0]] <= i_rx_byte;
        end
        r_rd_data <= r_mem[r_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_hdr       <= HDR_RESET;
            r_cmd       <= 8'h00;
            r_len       <= 6'd0;
            r_seq       <= 8'h00;
            r_fill      <= 6'd0;
            r_crc       <= CRC_INIT;
            r_rd_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            if (i_cfg_we) begin
                r_hdr <= i_cfg_data;
            end
            r_cmd       <= n_cmd;
            r_len       <= n_len;
            r_seq       <= n_seq;
            r_fill      <= n_fill;
            r_crc       <= n_crc;
            r_rd_idx    <= n_rd_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_idx    <= n_out_idx;
        r_out_data   <= n_out_data;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
        r_out_cmd    <= n_out_cmd;
        r_out_seq    <= n_out_seq;
        r_out_len    <= n_out_len;
    end

    assign o_res_valid      = r_out_valid;
    assign o_frame_command  = r_out_cmd;
    assign o_frame_sequence = r_out_seq;
    assign o_payload_length = r_out_len;
    assign o_byte_index     = r_out_idx;
    assign o_data_byte      = r_out_data;
    assign o_status         = r_out_status;
    assign o_last           = r_out_last;

endmodule
